// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the slot timer table
// Holds the table size, the field widths, the command, kind and status codes,
// and the types that connect the controller to the datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int SLOTS    = 32;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int COUNT_W  = $clog2(SLOTS + 1);
   localparam int OWNER_W  = 31;
   localparam int CTX_W    = 32;
   localparam int TIME_W   = 32;
   localparam int DELAY_W  = 16;
   localparam int REM_W    = 26;
   localparam int FIELD_W  = 5;

   localparam logic [TIME_W-1:0] MS_PER_S = TIME_W'(1000);
   localparam logic [REM_W-1:0]  REM_MAX  = {REM_W{1'b1}};

   typedef enum logic [2:0] {
      CMD_ALLOC   = 3'd0,
      CMD_ARM     = 3'd1,
      CMD_CANCEL  = 3'd2,
      CMD_RELEASE = 3'd3,
      CMD_SCAN    = 3'd4,
      CMD_TICK    = 3'd5,
      CMD_RSVD6   = 3'd6,
      CMD_RSVD7   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_REPLY   = 2'd0,
      KIND_EXPIRY  = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_FREE    = 2'd1,
      STAT_MISMATCH   = 2'd2,
      STAT_OWNER_ZERO = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SUMMARY
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LATCH,
      OP_EXEC,
      OP_SCAN,
      OP_SUMMARY
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic scan_last;
   } sts_type;

endpackage

// ===== sv/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl: sequencing state machine of the slot timer table
// Takes requests, steps the datapath through a command or a full scan.
// ----------------------------------------------------------------------------
module stt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2:0]       req_command,
   input  stt_pkg::sts_type sts,
   output stt_pkg::ctl_type ctl,
   output logic             busy
);

   stt_pkg::state_type state_ff, state_in;
   stt_pkg::cmd_type   cmd;

   assign cmd = stt_pkg::cmd_type'(req_command);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stt_pkg::ST_IDLE: begin
            if (start) begin
               case (cmd)
                  stt_pkg::CMD_ALLOC, stt_pkg::CMD_ARM, stt_pkg::CMD_CANCEL,
                  stt_pkg::CMD_RELEASE, stt_pkg::CMD_TICK: state_in = stt_pkg::ST_EXEC;
                  stt_pkg::CMD_SCAN: state_in = stt_pkg::ST_SCAN;
                  default: state_in = stt_pkg::ST_IDLE;
               endcase
            end
         end
         stt_pkg::ST_EXEC: state_in = stt_pkg::ST_IDLE;
         stt_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = stt_pkg::ST_SUMMARY;
         end
         stt_pkg::ST_SUMMARY: state_in = stt_pkg::ST_IDLE;
         default: state_in = stt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.op = stt_pkg::OP_NONE;
      busy   = 1'b1;
      case (state_ff)
         stt_pkg::ST_IDLE: begin
            busy   = 1'b0;
            ctl.op = start ? stt_pkg::OP_LATCH : stt_pkg::OP_NONE;
         end
         stt_pkg::ST_EXEC:    ctl.op = stt_pkg::OP_EXEC;
         stt_pkg::ST_SCAN:    ctl.op = stt_pkg::OP_SCAN;
         stt_pkg::ST_SUMMARY: ctl.op = stt_pkg::OP_SUMMARY;
         default:             ctl.op = stt_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= stt_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== sv/stt_datapath.sv =====
// ----------------------------------------------------------------------------
// stt_datapath: slot storage, free stack, clock and result register
// Executes the operation the controller selects, one slot per scan cycle.
// ----------------------------------------------------------------------------
module stt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  stt_pkg::ctl_type                ctl,
   output stt_pkg::sts_type                sts,
   input  logic [2:0]                      req_command,
   input  logic [stt_pkg::FIELD_W-1:0]     req_slot,
   input  logic [stt_pkg::OWNER_W-1:0]     req_owner,
   input  logic [stt_pkg::DELAY_W-1:0]     req_delay_seconds,
   input  logic [stt_pkg::CTX_W-1:0]       req_context_req,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_kind,
   output logic [1:0]                      rsp_status,
   output logic [stt_pkg::FIELD_W-1:0]     rsp_slot_out,
   output logic [stt_pkg::OWNER_W-1:0]     rsp_owner_out,
   output logic [stt_pkg::CTX_W-1:0]       rsp_context_out,
   output logic [stt_pkg::REM_W-1:0]       rsp_remaining_ms,
   output logic                            rsp_found,
   output logic                            rsp_last
);

   localparam int SW = stt_pkg::SLOT_W;
   localparam int CW = stt_pkg::COUNT_W;

   // Slot storage.
   logic [stt_pkg::OWNER_W-1:0] owner_ff [stt_pkg::SLOTS];
   logic [stt_pkg::OWNER_W-1:0] owner_in [stt_pkg::SLOTS];
   logic [stt_pkg::SLOTS-1:0]   armed_ff, armed_in;
   logic [stt_pkg::TIME_W-1:0]  deadline_ff [stt_pkg::SLOTS];
   logic [stt_pkg::TIME_W-1:0]  deadline_in [stt_pkg::SLOTS];
   logic [stt_pkg::CTX_W-1:0]   context_ff [stt_pkg::SLOTS];
   logic [stt_pkg::CTX_W-1:0]   context_in [stt_pkg::SLOTS];
   logic [SW-1:0]               stack_ff [stt_pkg::SLOTS];
   logic [SW-1:0]               stack_in [stt_pkg::SLOTS];
   logic [CW-1:0]               count_ff, count_in;
   logic [stt_pkg::TIME_W-1:0]  now_ff, now_in;

   // Latched request.
   stt_pkg::cmd_type            cmd_ff, cmd_in;
   logic [stt_pkg::FIELD_W-1:0] slot_ff, slot_in;
   logic [stt_pkg::OWNER_W-1:0] rowner_ff, rowner_in;
   logic [stt_pkg::CTX_W-1:0]   rctx_ff, rctx_in;
   logic [stt_pkg::TIME_W-1:0]  prod_ff, prod_in;

   // Scan state.
   logic [SW-1:0]               idx_ff, idx_in;
   logic [SW-1:0]               best_ff, best_in;
   logic [stt_pkg::REM_W-1:0]   brem_ff, brem_in;
   logic                        found_ff, found_in;

   // Result register.
   logic                        vld_ff, vld_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [1:0]                  stat_ff, stat_in;
   logic [stt_pkg::FIELD_W-1:0] oslot_ff, oslot_in;
   logic [stt_pkg::OWNER_W-1:0] oown_ff, oown_in;
   logic [stt_pkg::CTX_W-1:0]   octx_ff, octx_in;
   logic [stt_pkg::REM_W-1:0]   orem_ff, orem_in;
   logic                        ofound_ff, ofound_in;
   logic                        olast_ff, olast_in;

   logic [SW-1:0]               rd_idx, top_idx, push_idx;
   logic [stt_pkg::OWNER_W-1:0] rd_owner;
   logic [stt_pkg::TIME_W-1:0]  diff;
   logic [stt_pkg::REM_W-1:0]   rem;
   logic                        slot_bad;

   assign sts.scan_last = (idx_ff == SW'(stt_pkg::SLOTS - 1));
   assign top_idx  = stack_ff[SW'(count_ff - 1'b1)];
   assign push_idx = SW'(count_ff);
   assign slot_bad = (32'(slot_ff) >= 32'(stt_pkg::SLOTS));

   always_comb begin
      case (ctl.op)
         stt_pkg::OP_EXEC:    rd_idx = SW'(slot_ff);
         stt_pkg::OP_SUMMARY: rd_idx = best_ff;
         default:             rd_idx = idx_ff;
      endcase
   end

   assign rd_owner = owner_ff[rd_idx];
   assign diff     = deadline_ff[rd_idx] - now_ff;
   assign rem      = (diff > stt_pkg::TIME_W'(stt_pkg::REM_MAX)) ? stt_pkg::REM_MAX
                                                                  : diff[stt_pkg::REM_W-1:0];

   always_comb begin
      owner_in    = owner_ff;
      armed_in    = armed_ff;
      deadline_in = deadline_ff;
      context_in  = context_ff;
      stack_in    = stack_ff;
      count_in    = count_ff;
      now_in      = now_ff;
      cmd_in      = cmd_ff;
      slot_in     = slot_ff;
      rowner_in   = rowner_ff;
      rctx_in     = rctx_ff;
      prod_in     = prod_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      brem_in     = brem_ff;
      found_in    = found_ff;
      vld_in      = 1'b0;
      kind_in     = kind_ff;
      stat_in     = stat_ff;
      oslot_in    = oslot_ff;
      oown_in     = oown_ff;
      octx_in     = octx_ff;
      orem_in     = orem_ff;
      ofound_in   = ofound_ff;
      olast_in    = olast_ff;

      case (ctl.op)
         stt_pkg::OP_LATCH: begin
            cmd_in    = stt_pkg::cmd_type'(req_command);
            slot_in   = req_slot;
            rowner_in = req_owner;
            rctx_in   = req_context_req;
            prod_in   = stt_pkg::TIME_W'(req_delay_seconds) * stt_pkg::MS_PER_S;
            idx_in    = '0;
            best_in   = '0;
            brem_in   = '0;
            found_in  = 1'b0;
         end
         stt_pkg::OP_EXEC: begin
            vld_in    = 1'b1;
            kind_in   = stt_pkg::KIND_REPLY;
            stat_in   = stt_pkg::STAT_OK;
            oslot_in  = slot_ff;
            oown_in   = rowner_ff;
            octx_in   = '0;
            orem_in   = '0;
            ofound_in = 1'b0;
            olast_in  = 1'b1;
            if (cmd_ff == stt_pkg::CMD_TICK) begin
               now_in   = now_ff + 1'b1;
               oslot_in = '0;
               oown_in  = '0;
            end else if (rowner_ff == '0) begin
               stat_in = stt_pkg::STAT_OWNER_ZERO;
            end else if (cmd_ff == stt_pkg::CMD_ALLOC) begin
               if (count_ff == '0) begin
                  stat_in  = stt_pkg::STAT_NO_FREE;
                  oslot_in = '0;
               end else begin
                  count_in            = count_ff - 1'b1;
                  owner_in[top_idx]   = rowner_ff;
                  context_in[top_idx] = rctx_ff;
                  armed_in[top_idx]   = 1'b0;
                  oslot_in            = stt_pkg::FIELD_W'(top_idx);
                  octx_in             = rctx_ff;
               end
            end else if (slot_bad || rd_owner != rowner_ff) begin
               stat_in = stt_pkg::STAT_MISMATCH;
            end else begin
               case (cmd_ff)
                  stt_pkg::CMD_ARM: begin
                     deadline_in[rd_idx] = now_ff + prod_ff;
                     armed_in[rd_idx]    = 1'b1;
                  end
                  stt_pkg::CMD_CANCEL: armed_in[rd_idx] = 1'b0;
                  default: begin
                     owner_in[rd_idx] = '0;
                     armed_in[rd_idx] = 1'b0;
                     if (count_ff < CW'(stt_pkg::SLOTS)) begin
                        stack_in[push_idx] = rd_idx;
                        count_in           = count_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         stt_pkg::OP_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (rd_owner != '0 && armed_ff[rd_idx]) begin
               if (diff[stt_pkg::TIME_W-1]) begin
                  vld_in    = 1'b1;
                  kind_in   = stt_pkg::KIND_EXPIRY;
                  stat_in   = stt_pkg::STAT_OK;
                  oslot_in  = stt_pkg::FIELD_W'(rd_idx);
                  oown_in   = rd_owner;
                  octx_in   = context_ff[rd_idx];
                  orem_in   = '0;
                  ofound_in = 1'b0;
                  olast_in  = 1'b0;
               end else if (!found_ff || rem < brem_ff) begin
                  found_in = 1'b1;
                  best_in  = rd_idx;
                  brem_in  = rem;
               end
            end
         end
         stt_pkg::OP_SUMMARY: begin
            vld_in    = 1'b1;
            kind_in   = stt_pkg::KIND_SUMMARY;
            stat_in   = stt_pkg::STAT_OK;
            olast_in  = 1'b1;
            ofound_in = found_ff;
            if (found_ff) begin
               oslot_in = stt_pkg::FIELD_W'(best_ff);
               oown_in  = rd_owner;
               octx_in  = context_ff[rd_idx];
               orem_in  = brem_ff;
            end else begin
               oslot_in = '0;
               oown_in  = '0;
               octx_in  = '0;
               orem_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < stt_pkg::SLOTS; i++) begin
            owner_ff[i] <= '0;
            stack_ff[i] <= SW'(i);
         end
         armed_ff <= '0;
         count_ff <= CW'(stt_pkg::SLOTS);
         now_ff   <= '0;
         vld_ff   <= 1'b0;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         owner_ff <= owner_in;
         stack_ff <= stack_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
         now_ff   <= now_in;
         vld_ff   <= vld_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      context_ff  <= context_in;
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      rowner_ff   <= rowner_in;
      rctx_ff     <= rctx_in;
      prod_ff     <= prod_in;
      best_ff     <= best_in;
      brem_ff     <= brem_in;
      kind_ff     <= kind_in;
      stat_ff     <= stat_in;
      oslot_ff    <= oslot_in;
      oown_ff     <= oown_in;
      octx_ff     <= octx_in;
      orem_ff     <= orem_in;
      ofound_ff   <= ofound_in;
      olast_ff    <= olast_in;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_status       = stat_ff;
   assign rsp_slot_out     = oslot_ff;
   assign rsp_owner_out    = oown_ff;
   assign rsp_context_out  = octx_ff;
   assign rsp_remaining_ms = orem_ff;
   assign rsp_found        = ofound_ff;
   assign rsp_last         = olast_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(stt_pkg::SLOTS))
      else $error("free count exceeds table size");

   a_exec_reply: assert property (@(posedge clock) disable iff (reset)
      ctl.op == stt_pkg::OP_EXEC |=> vld_ff && olast_ff && kind_ff == stt_pkg::KIND_REPLY)
      else $error("command did not produce a final reply");

   a_summary: assert property (@(posedge clock) disable iff (reset)
      ctl.op == stt_pkg::OP_SUMMARY |=> vld_ff && olast_ff && kind_ff == stt_pkg::KIND_SUMMARY)
      else $error("scan did not end with a summary");

   a_expiry_not_last: assert property (@(posedge clock) disable iff (reset)
      vld_ff && kind_ff == stt_pkg::KIND_EXPIRY |-> !olast_ff && $past(ctl.op) == stt_pkg::OP_SCAN)
      else $error("expiry event outside a scan or marked last");
`endif

endmodule

// ===== sv/slot_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// slot_timer_table_top: table of timer slots with a millisecond clock
// Allocate, arm, cancel, release, scan and tick requests on a start/busy port.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. Every result is
// presented for exactly one cycle with rsp_valid high, and the receiver
// cannot stall it, so it must capture each result in the cycle it appears.
// Allocate, arm, cancel, release and tick pass through the EXEC state, in
// which busy is high, and their reply is registered from it. A scan visits
// one slot per cycle through the single read port of the slot storage,
// giving expiry events as it goes, then a summary, with busy high throughout.
// Unused command codes six and seven are accepted and produce no result.
// The final result of every request carries rsp_last.
module slot_timer_table_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_command,
   input  logic [stt_pkg::FIELD_W-1:0] req_slot,
   input  logic [stt_pkg::OWNER_W-1:0] req_owner,
   input  logic [stt_pkg::DELAY_W-1:0] req_delay_seconds,
   input  logic [stt_pkg::CTX_W-1:0]   req_context_req,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_kind,
   output logic [1:0]                  rsp_status,
   output logic [stt_pkg::FIELD_W-1:0] rsp_slot_out,
   output logic [stt_pkg::OWNER_W-1:0] rsp_owner_out,
   output logic [stt_pkg::CTX_W-1:0]   rsp_context_out,
   output logic [stt_pkg::REM_W-1:0]   rsp_remaining_ms,
   output logic                        rsp_found,
   output logic                        rsp_last
);

   // The controller only sequences; all storage lives in the datapath.
   stt_pkg::ctl_type ctl;
   stt_pkg::sts_type sts;

   stt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl),
      .busy        (busy)
   );

   stt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_slot          (req_slot),
      .req_owner         (req_owner),
      .req_delay_seconds (req_delay_seconds),
      .req_context_req   (req_context_req),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_owner_out     (rsp_owner_out),
      .rsp_context_out   (rsp_context_out),
      .rsp_remaining_ms  (rsp_remaining_ms),
      .rsp_found         (rsp_found),
      .rsp_last          (rsp_last)
   );

endmodule
